// ----- src/ibtd_pkg.sv -----
package ibtd_pkg;

  localparam int KEY_COUNT    = 512;
  localparam int BUTTON_COUNT = 8;
  localparam int BIND_COUNT   = 6;

  localparam int WORD_COUNT = 6;
  localparam int WORD_W     = 56;
  localparam int WORD_AW    = 3;
  localparam int CFG_AW     = 3;
  localparam int TIMER_W    = 24;
  localparam int DT_W       = 20;
  localparam int MASK_W     = 6;
  localparam int CODE_W     = 9;
  localparam int BTN_W      = 3;
  localparam int BTN_SLOTS  = 8;

  // key bitmaps are kept as rows of 32 bits
  localparam int ROW_W    = 32;
  localparam int BIT_AW   = 5;
  localparam int KEY_ROWS = (KEY_COUNT + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
  localparam int CP_W     = $clog2(KEY_ROWS + 1);
  localparam int BIND_AW  = (BIND_COUNT > 1) ? $clog2(BIND_COUNT) : 1;

  localparam logic [CFG_AW-1:0] REG_DWIN = 3'd6;
  localparam logic [TIMER_W-1:0] DWIN_RESET = 24'd200000;

  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_BTN   = 2'd1;
  localparam logic [1:0] FUNC_FRAME = 2'd2;

  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;

  localparam logic [1:0] TRIG_PRESS   = 2'd0;
  localparam logic [1:0] TRIG_RELEASE = 2'd1;
  localparam logic [1:0] TRIG_HELD    = 2'd2;
  localparam logic [1:0] TRIG_DOUBLE  = 2'd3;

  localparam int EN_BIT = 26;

  typedef struct packed {
    logic [TIMER_W-1:0] timeout;
    logic               en;
    logic [1:0]         trig;
    logic               mod_en;
    logic [CODE_W-1:0]  mod;
    logic               btn_en;
    logic [BTN_W-1:0]   btn;
    logic               key_en;
    logic [CODE_W-1:0]  key;
  } binding_t;

  typedef enum logic [1:0] {
    ALU_SUB_SAT,
    ALU_ADD_SAT,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [TIMER_W-1:0] a;
    logic [TIMER_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIMER_W-1:0] value;
    logic               flag;
  } alu_res_t;

  typedef struct packed {
    logic              rd;
    logic [ROW_AW-1:0] row_a;
    logic [ROW_AW-1:0] row_b;
    logic [ROW_AW-1:0] row_bef;
    logic              wr_now;
    logic [ROW_AW-1:0] now_row;
    logic [ROW_W-1:0]  now_data;
    logic              wr_bef;
    logic [ROW_AW-1:0] bef_row;
    logic [ROW_W-1:0]  bef_data;
  } km_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] now_a;
    logic [ROW_W-1:0] now_b;
    logic [ROW_W-1:0] bef;
  } km_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KWR,
    ST_WIN,
    ST_CMP,
    ST_ADD,
    ST_COPY,
    ST_DONE
  } state_t;

  function automatic binding_t unpack_binding(input logic [WORD_W-1:0] w);
    binding_t b;
    b.key     = w[8:0];
    b.key_en  = w[9];
    b.btn     = w[12:10];
    b.btn_en  = w[13];
    b.mod     = w[22:14];
    b.mod_en  = w[23];
    b.trig    = w[25:24];
    b.en      = w[26];
    b.timeout = w[55:32];
    return b;
  endfunction

  function automatic logic key_in_range(input logic [CODE_W-1:0] code);
    return 10'(code) < 10'(KEY_COUNT);
  endfunction

  function automatic logic btn_in_range(input logic [CODE_W-1:0] code);
    return 10'(code) < 10'(BUTTON_COUNT);
  endfunction

  function automatic logic [ROW_AW-1:0] key_row(input logic [CODE_W-1:0] code);
    return ROW_AW'(code >> BIT_AW);
  endfunction

  function automatic logic edge_hit(input logic [1:0] trig, input logic now,
                                    input logic bef);
    logic r;
    unique case (trig)
      TRIG_RELEASE: r = !now && bef;
      TRIG_HELD:    r = now;
      default:      r = now && !bef;
    endcase
    return r;
  endfunction

endpackage

// ----- src/ibtd_alu.sv -----
module ibtd_alu (
  input  ibtd_pkg::alu_req_t req,
  output ibtd_pkg::alu_res_t res
);
  import ibtd_pkg::*;

  logic [TIMER_W-1:0] b_eff;
  logic               cin;
  logic [TIMER_W:0]   sum;
  logic               borrow;

  // one 24-bit adder, b inverted for the subtract and compare ops
  always_comb begin
    b_eff  = (req.op == ALU_ADD_SAT) ? req.b : ~req.b;
    cin    = (req.op != ALU_ADD_SAT);
    sum    = {1'b0, req.a} + {1'b0, b_eff} + {{TIMER_W{1'b0}}, cin};
    borrow = !sum[TIMER_W];
  end

  always_comb begin
    unique case (req.op)
      ALU_ADD_SAT: begin
        res.value = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
        res.flag  = sum[TIMER_W];
      end
      ALU_SUB_SAT: begin
        res.value = borrow ? '0 : sum[TIMER_W-1:0];
        res.flag  = borrow;
      end
      ALU_LT: begin
        res.value = sum[TIMER_W-1:0];
        res.flag  = borrow;
      end
      default: begin
        res.value = '0;
        res.flag  = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/ibtd_keymap.sv -----
module ibtd_keymap (
  input  logic              clk,
  input  logic              rst,
  input  ibtd_pkg::km_req_t req,
  output ibtd_pkg::km_rd_t  rd
);
  import ibtd_pkg::*;

  logic [ROW_W-1:0]    now_mem [KEY_ROWS];
  logic [ROW_W-1:0]    bef_mem [KEY_ROWS];
  logic [KEY_ROWS-1:0] now_vld;
  logic [KEY_ROWS-1:0] bef_vld;
  logic [ROW_W-1:0]    a_q;
  logic [ROW_W-1:0]    b_q;
  logic [ROW_W-1:0]    c_q;
  logic                a_v;
  logic                b_v;
  logic                c_v;

  always_ff @(posedge clk) begin
    if (req.wr_now) begin
      now_mem[req.now_row] <= req.now_data;
    end
    if (req.wr_bef) begin
      bef_mem[req.bef_row] <= req.bef_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      a_q <= now_mem[req.row_a];
      b_q <= now_mem[req.row_b];
      c_q <= bef_mem[req.row_bef];
    end
  end

  // a row never written since reset reads as all keys up
  always_ff @(posedge clk) begin
    if (rst) begin
      now_vld <= '0;
      bef_vld <= '0;
      a_v     <= 1'b0;
      b_v     <= 1'b0;
      c_v     <= 1'b0;
    end else begin
      if (req.wr_now) begin
        now_vld[req.now_row] <= 1'b1;
      end
      if (req.wr_bef) begin
        bef_vld[req.bef_row] <= 1'b1;
      end
      if (req.rd) begin
        a_v <= now_vld[req.row_a];
        b_v <= now_vld[req.row_b];
        c_v <= bef_vld[req.row_bef];
      end
    end
  end

  assign rd.now_a = a_v ? a_q : '0;
  assign rd.now_b = b_v ? b_q : '0;
  assign rd.bef   = c_v ? c_q : '0;

endmodule

// ----- src/input_binding_trigger_detector.sv -----
// Input binding trigger detector.
// Input channel (in_valid/in_ready): one beat carries func, index, action and
// elapsed_us. Key and mouse button beats update the current bitmaps and give
// no result. A frame beat checks every enabled binding in order and gives one
// fired_mask beat on the output channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..5 writes a
// binding word, 6 writes the double-press window; other indexes are dropped.
// Write config only while the block is idle.
// Steps: a button beat is done on acceptance; a key beat adds a write step
// (read-modify-write of a 32-key row). A frame runs a window step per binding,
// a trigger check and, while a cooldown runs, an add step if enabled, then
// the row copy and a done step. Each binding steps its timers through one
// shared 24-bit adder; the previous-key map is refreshed one row per cycle.
// The block is not ready while a beat is being worked on. A finished mask
// sits in the output register; if a second frame finishes before it is taken,
// the block holds in its last step until out_ready.
// Reset (rst, synchronous) clears bitmaps and timers (cooldowns read as
// elapsed) and restores register defaults; there is no clearing pass.
module input_binding_trigger_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [ibtd_pkg::CODE_W-1:0]   index,
  input  logic [1:0]                    action,
  input  logic [ibtd_pkg::DT_W-1:0]     elapsed_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ibtd_pkg::MASK_W-1:0]   fired_mask,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ibtd_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [ibtd_pkg::WORD_W-1:0]   cfg_data
);
  import ibtd_pkg::*;

  state_t state, state_next;

  logic [WORD_W-1:0]     words [WORD_COUNT];
  logic [TIMER_W-1:0]    dwin;
  logic [BTN_SLOTS-1:0]  button_now;
  logic [BTN_SLOTS-1:0]  button_before;
  logic [TIMER_W-1:0]    cooldown [BIND_COUNT];
  logic [TIMER_W-1:0]    window [BIND_COUNT];
  logic [BIND_COUNT-1:0] first_seen;

  logic [BIND_AW-1:0] bi;
  logic [CP_W-1:0]    cp;
  logic [CP_W-1:0]    cp_m1;
  logic [DT_W-1:0]    dt;
  logic [MASK_W-1:0]  mask;
  logic [ROW_AW-1:0]  ev_row;
  logic [BIT_AW-1:0]  ev_bit;
  logic               ev_val;

  km_req_t  km_req;
  km_rd_t   km_rd;
  alu_req_t alu_req;
  alu_res_t alu_res;
  binding_t bw;

  logic in_acc, act_ok, key_ev, out_free, bind_last, copy_last;
  logic win_nz, cool_wait, k_now, k_bef, m_now, b_now, b_bef, gate, hit;
  logic is_double, fire_now;
  logic [TIMER_W-1:0] dt_ext;
  logic [MASK_W-1:0]  en_vec;

  ibtd_keymap u_keymap (
    .clk (clk),
    .rst (rst),
    .req (km_req),
    .rd  (km_rd)
  );

  ibtd_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign cfg_ready = 1'b1;
  assign bw        = unpack_binding(words[WORD_AW'(bi)]);
  assign in_acc    = in_valid && in_ready;
  assign act_ok    = (action == ACT_RELEASE) || (action == ACT_PRESS);
  assign key_ev    = (func == FUNC_KEY) && act_ok && key_in_range(index);
  assign out_free  = !out_valid || out_ready;
  assign bind_last = (bi == BIND_AW'(BIND_COUNT - 1));
  assign copy_last = (cp == CP_W'(KEY_ROWS));
  assign cp_m1     = cp - CP_W'(1);
  assign dt_ext    = TIMER_W'(dt);
  assign win_nz    = |window[bi];
  assign cool_wait = (bw.timeout != '0) && alu_res.flag;
  assign is_double = (bw.trig == TRIG_DOUBLE);

  // trigger check on the rows read during the window step
  always_comb begin
    k_now = key_in_range(bw.key) && km_rd.now_a[bw.key[BIT_AW-1:0]];
    k_bef = key_in_range(bw.key) && km_rd.bef[bw.key[BIT_AW-1:0]];
    m_now = key_in_range(bw.mod) && km_rd.now_b[bw.mod[BIT_AW-1:0]];
    b_now = btn_in_range(CODE_W'(bw.btn)) && button_now[bw.btn];
    b_bef = btn_in_range(CODE_W'(bw.btn)) && button_before[bw.btn];
    gate  = !bw.mod_en || m_now;
    hit   = (bw.key_en && edge_hit(bw.trig, k_now, k_bef)) ||
            (bw.btn_en && edge_hit(bw.trig, b_now, b_bef));
    fire_now = (state == ST_CMP) && !cool_wait && gate && hit &&
               (!is_double || (first_seen[bi] && win_nz));
  end

  always_comb begin
    en_vec = '0;
    for (int i = 0; i < BIND_COUNT; i++) begin
      en_vec[i] = words[i][EN_BIT];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && func == FUNC_FRAME) begin
          state_next = ST_WIN;
        end else if (in_acc && key_ev) begin
          state_next = ST_KWR;
        end
      end
      ST_KWR: state_next = ST_IDLE;
      ST_WIN: begin
        if (bw.en) begin
          state_next = ST_CMP;
        end else if (bind_last) begin
          state_next = ST_COPY;
        end
      end
      ST_CMP: begin
        if (cool_wait) begin
          state_next = ST_ADD;
        end else begin
          state_next = bind_last ? ST_COPY : ST_WIN;
        end
      end
      ST_ADD:  state_next = bind_last ? ST_COPY : ST_WIN;
      ST_COPY: state_next = copy_last ? ST_DONE : ST_COPY;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    km_req          = '0;
    km_req.now_row  = ev_row;
    km_req.now_data = km_rd.now_a;
    km_req.bef_row  = cp_m1[ROW_AW-1:0];
    km_req.bef_data = km_rd.now_a;
    alu_req.op      = ALU_SUB_SAT;
    alu_req.a       = window[bi];
    alu_req.b       = dt_ext;
    unique case (state)
      ST_IDLE: begin
        km_req.rd    = 1'b1;
        km_req.row_a = key_row(index);
      end
      ST_KWR: begin
        km_req.wr_now           = 1'b1;
        km_req.now_data[ev_bit] = ev_val;
      end
      ST_WIN: begin
        km_req.rd      = 1'b1;
        km_req.row_a   = key_row(bw.key);
        km_req.row_b   = key_row(bw.mod);
        km_req.row_bef = key_row(bw.key);
      end
      ST_CMP: begin
        alu_req.op = ALU_LT;
        alu_req.a  = cooldown[bi];
        alu_req.b  = bw.timeout;
      end
      ST_ADD: begin
        alu_req.op = ALU_ADD_SAT;
        alu_req.a  = cooldown[bi];
      end
      ST_COPY: begin
        // read row cp, write the row read just before it (row cp - 1) into the previous-key map
        km_req.rd     = !copy_last;
        km_req.row_a  = cp[ROW_AW-1:0];
        km_req.wr_bef = (cp != '0);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bi        <= '0;
      cp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        bi <= '0;
        cp <= '0;
      end
      if ((state == ST_WIN && !bw.en) || (state == ST_CMP && !cool_wait) ||
          state == ST_ADD) begin
        bi <= bi + BIND_AW'(1);
      end
      if (state == ST_COPY) begin
        cp <= cp + CP_W'(1);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_row <= key_row(index);
      ev_bit <= index[BIT_AW-1:0];
      ev_val <= action[0];
      dt     <= elapsed_us;
      mask   <= '0;
    end else if (fire_now) begin
      mask <= mask | (MASK_W'(1) << bi);
    end
    if (state == ST_DONE && out_free) begin
      fired_mask <= mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        words[i] <= '0;
      end
      dwin <= DWIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_AW'(WORD_COUNT)) begin
        words[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_DWIN) begin
        dwin <= cfg_data[TIMER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_now    <= '0;
      button_before <= '0;
    end else begin
      if (in_acc && func == FUNC_BTN && act_ok && btn_in_range(index)) begin
        button_now[index[BTN_W-1:0]] <= action[0];
      end
      if (state == ST_COPY && copy_last) begin
        button_before <= button_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BIND_COUNT; i++) begin
        cooldown[i] <= '1;
        window[i]   <= '0;
      end
      first_seen <= '0;
    end else begin
      unique case (state)
        ST_WIN: begin
          if (bw.en && win_nz) begin
            window[bi] <= alu_res.value;
            if (alu_res.value == '0) begin
              first_seen[bi] <= 1'b0;
            end
          end
        end
        ST_CMP: begin
          if (!cool_wait && gate && hit) begin
            if (!is_double) begin
              cooldown[bi] <= '0;
            end else if (!first_seen[bi]) begin
              first_seen[bi] <= 1'b1;
              window[bi]     <= dwin;
            end else if (win_nz) begin
              first_seen[bi] <= 1'b0;
              window[bi]     <= '0;
              cooldown[bi]   <= '0;
            end
          end
        end
        ST_ADD: cooldown[bi] <= alu_res.value;
        default: ;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == ST_IDLE) && !out_valid)
    else $error("block not idle after reset");

  a_cmp_after_win: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> ($past(state) == ST_WIN))
    else $error("trigger check without window step");

  a_window_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (window[bi] == '0 || first_seen[bi]))
    else $error("double-press window running without first press");

  a_mask_enabled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> out_valid && ((fired_mask & ~en_vec) == '0))
    else $error("disabled binding reported as fired");

endmodule

// ----- tb/tb_input_binding_trigger_detector.sv -----
`timescale 1ns / 1ps

import ibtd_pkg::*;

class binding_scoreboard;
  logic [WORD_W-1:0]       words [WORD_COUNT];
  logic [TIMER_W-1:0]      dwin_us;
  logic [KEY_COUNT-1:0]    key_now;
  logic [KEY_COUNT-1:0]    key_before;
  logic [BUTTON_COUNT-1:0] btn_now;
  logic [BUTTON_COUNT-1:0] btn_before;
  logic [TIMER_W-1:0]      cooldown [BIND_COUNT];
  logic [TIMER_W-1:0]      dwin_left [BIND_COUNT];
  logic                    first_seen [BIND_COUNT];
  logic [MASK_W-1:0]       masks_due [$];
  int                      errors;

  function new();
    foreach (words[k]) words[k] = '0;
    dwin_us = DWIN_RESET;
    key_now = '0;
    key_before = '0;
    btn_now = '0;
    btn_before = '0;
    for (int k = 0; k < BIND_COUNT; k++) begin
      cooldown[k] = '1;
      dwin_left[k] = '0;
      first_seen[k] = 1'b0;
    end
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_AW-1:0] idx, logic [WORD_W-1:0] data);
    if (idx == REG_DWIN) begin
      dwin_us = data[TIMER_W-1:0];
    end else if (int'(idx) < WORD_COUNT) begin
      words[idx] = data;
    end
  endfunction

  function logic trig_met(logic [1:0] trig, logic now, logic bef);
    if (trig == TRIG_RELEASE) return !now && bef;
    if (trig == TRIG_HELD) return now;
    return now && !bef;
  endfunction

  function logic key_at(logic [KEY_COUNT-1:0] map, logic [CODE_W-1:0] code);
    return (int'(code) < KEY_COUNT) ? map[code] : 1'b0;
  endfunction

  function logic btn_at(logic [BUTTON_COUNT-1:0] map, logic [BTN_W-1:0] code);
    return (int'(code) < BUTTON_COUNT) ? map[code] : 1'b0;
  endfunction

  // walks the bindings for one frame and queues the mask it should give
  function void run_frame(logic [DT_W-1:0] dt);
    logic [WORD_W-1:0]  w;
    logic [1:0]         trig;
    logic [TIMER_W-1:0] tmo;
    logic [TIMER_W:0]   sum;
    logic               gate;
    logic               hit;
    logic [MASK_W-1:0]  mask;
    mask = '0;
    for (int k = 0; k < BIND_COUNT; k++) begin
      w = words[k];
      trig = w[25:24];
      tmo = w[55:32];
      if (!w[EN_BIT]) continue;
      if (dwin_left[k] != '0) begin
        dwin_left[k] = (dwin_left[k] > TIMER_W'(dt)) ? dwin_left[k] - TIMER_W'(dt) : '0;
        if (dwin_left[k] == '0) first_seen[k] = 1'b0;
      end
      if (tmo != '0 && cooldown[k] < tmo) begin
        sum = cooldown[k] + dt;
        cooldown[k] = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
        continue;
      end
      gate = !w[23] || key_at(key_now, w[22:14]);
      hit = 1'b0;
      if (w[9]) hit = trig_met(trig, key_at(key_now, w[8:0]), key_at(key_before, w[8:0]));
      if (w[13]) begin
        hit = hit || trig_met(trig, btn_at(btn_now, w[12:10]), btn_at(btn_before, w[12:10]));
      end
      if (!(gate && hit)) continue;
      if (trig == TRIG_DOUBLE) begin
        if (!first_seen[k]) begin
          first_seen[k] = 1'b1;
          dwin_left[k] = dwin_us;
        end else if (dwin_left[k] != '0) begin
          mask[k] = 1'b1;
          first_seen[k] = 1'b0;
          dwin_left[k] = '0;
          cooldown[k] = '0;
        end
      end else begin
        mask[k] = 1'b1;
        cooldown[k] = '0;
      end
    end
    key_before = key_now;
    btn_before = btn_now;
    masks_due.push_back(mask);
  endfunction

  function void take_beat(logic [1:0] f, logic [CODE_W-1:0] idx, logic [1:0] act,
                          logic [DT_W-1:0] dt);
    if (f == FUNC_FRAME) begin
      run_frame(dt);
    end else if ((f == FUNC_KEY || f == FUNC_BTN) && (act == ACT_PRESS || act == ACT_RELEASE)) begin
      if (f == FUNC_KEY && int'(idx) < KEY_COUNT) key_now[idx] = (act == ACT_PRESS);
      else if (f == FUNC_BTN && int'(idx) < BUTTON_COUNT) btn_now[idx] = (act == ACT_PRESS);
    end
  endfunction

  function void check_mask(logic [MASK_W-1:0] got);
    logic [MASK_W-1:0] want;
    if (masks_due.size() == 0) begin
      $display("%0t: fired_mask beat with none expected, actual %02h", $time, got);
      errors++;
      return;
    end
    want = masks_due.pop_front();
    if (got !== want) begin
      $display("%0t: fired_mask mismatch, expected %02h actual %02h", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return masks_due.size();
  endfunction
endclass

module tb_input_binding_trigger_detector;

  localparam logic [1:0]        FUNC_NONE   = 2'd3;
  localparam logic [1:0]        ACT_REPEAT  = 2'd2;
  localparam logic [1:0]        ACT_UNKNOWN = 2'd3;
  localparam logic [CFG_AW-1:0] REG_UNUSED  = 3'd7;
  localparam int                PHASES      = 8;
  localparam int                PHASE_ITEMS = 220;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          func;
  logic [CODE_W-1:0]   index;
  logic [1:0]          action;
  logic [DT_W-1:0]     elapsed_us;
  logic                out_valid;
  logic                out_ready;
  logic [MASK_W-1:0]   fired_mask;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_AW-1:0]   cfg_index;
  logic [WORD_W-1:0]   cfg_data;

  binding_scoreboard   sb = new();
  logic [CODE_W-1:0]   hot_keys [8];
  bit                  calm = 1'b0;

  input_binding_trigger_detector u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .index      (index),
    .action     (action),
    .elapsed_us (elapsed_us),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fired_mask (fired_mask),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_mask(fired_mask);
  end

  // valid stays high after the beat is taken so back-to-back beats need one assignment
  task automatic send_item(logic [1:0] f, logic [CODE_W-1:0] idx, logic [1:0] act,
                           logic [DT_W-1:0] dt);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    index      <= idx;
    action     <= act;
    elapsed_us <= dt;
    do @(posedge clk); while (!in_ready);
    sb.take_beat(f, idx, act, dt);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    // key beats give no result, so allow for the longest frame on top
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] make_binding(logic [CODE_W-1:0] key,
      logic key_en, logic [BTN_W-1:0] btn, logic btn_en, logic [CODE_W-1:0] mod,
      logic mod_en, logic [1:0] trig, logic en, logic [TIMER_W-1:0] tmo);
    logic [WORD_W-1:0] w;
    w = '0;
    w[8:0]   = key;
    w[9]     = key_en;
    w[12:10] = btn;
    w[13]    = btn_en;
    w[22:14] = mod;
    w[23]    = mod_en;
    w[25:24] = trig;
    w[26]    = en;
    w[55:32] = tmo;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] random_binding();
    logic [WORD_W-1:0]  w;
    logic [TIMER_W-1:0] tmo;
    int                 pick;
    pick = $urandom_range(19);
    if (pick < 8) tmo = '0;
    else if (pick < 16) tmo = TIMER_W'($urandom_range(1, 5000));
    else if (pick < 19) tmo = TIMER_W'($urandom);
    else tmo = '1;
    w = make_binding(hot_keys[$urandom_range(7)], $urandom_range(3) != 0,
                     BTN_W'($urandom_range(7)), 1'($urandom_range(1)),
                     hot_keys[$urandom_range(7)], $urandom_range(9) < 3,
                     2'($urandom_range(3)), $urandom_range(99) < 85, tmo);
    // unused bits between en and timeout get random junk
    w[31:27] = 5'($urandom);
    return w;
  endfunction

  function automatic logic [DT_W-1:0] random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 85) return DT_W'($urandom_range(1, 1500));
    if (pick < 95) return DT_W'($urandom);
    return '1;
  endfunction

  task automatic run_directed();
    cfg_write(0, make_binding(9'd5, 1, 0, 0, 0, 0, TRIG_PRESS, 1, 0));
    cfg_write(1, make_binding(9'd5, 1, 0, 0, 0, 0, TRIG_RELEASE, 1, 0));
    cfg_write(2, make_binding(0, 0, 3'd0, 1, 9'd511, 1, TRIG_HELD, 1, 0));
    cfg_write(3, make_binding(9'd0, 1, 0, 0, 0, 0, TRIG_DOUBLE, 1, 0));
    cfg_write(4, make_binding(9'd5, 1, 0, 0, 0, 0, TRIG_PRESS, 0, 0));
    cfg_write(5, make_binding(0, 0, 3'd7, 1, 0, 0, TRIG_PRESS, 1, 24'd1000));
    cfg_write(REG_UNUSED, '1);
    cfg_done();
    send_item(FUNC_KEY, 9'd5, ACT_PRESS, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, '0);
    send_item(FUNC_KEY, 9'd5, ACT_RELEASE, '0);
    send_item(FUNC_FRAME, 9'd511, ACT_UNKNOWN, '1);
    send_item(FUNC_KEY, 9'd5, ACT_REPEAT, '0);
    send_item(FUNC_KEY, 9'd5, ACT_UNKNOWN, '1);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, '0);
    send_item(FUNC_BTN, 9'd0, ACT_PRESS, '0);
    send_item(FUNC_KEY, 9'd511, ACT_PRESS, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, 20'd10);
    // button number past the button count
    send_item(FUNC_BTN, 9'd300, ACT_PRESS, '0);
    send_item(FUNC_BTN, 9'd7, ACT_PRESS, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, '0);
    send_item(FUNC_BTN, 9'd7, ACT_RELEASE, '0);
    send_item(FUNC_BTN, 9'd7, ACT_PRESS, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, 20'd500);
    // double press on key 0 inside the window
    send_item(FUNC_KEY, 9'd0, ACT_PRESS, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, 20'd100);
    send_item(FUNC_KEY, 9'd0, ACT_RELEASE, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, 20'd100);
    send_item(FUNC_KEY, 9'd0, ACT_PRESS, '0);
    send_item(FUNC_FRAME, '0, ACT_RELEASE, 20'd100);
    send_item(FUNC_NONE, 9'd511, ACT_UNKNOWN, '1);
    send_item(FUNC_FRAME, '0, ACT_PRESS, '1);
  endtask

  task automatic configure(int phase);
    logic [TIMER_W-1:0] dwin;
    hot_keys[0] = '0;
    hot_keys[1] = CODE_W'(KEY_COUNT - 1);
    for (int k = 2; k < 8; k++) hot_keys[k] = CODE_W'($urandom_range(KEY_COUNT - 1));
    case (phase)
      1: dwin = '1;
      4: dwin = '0;
      6: dwin = TIMER_W'($urandom);
      7: dwin = DWIN_RESET;
      default: dwin = TIMER_W'($urandom_range(500, 6000));
    endcase
    for (int k = 0; k < WORD_COUNT; k++) begin
      cfg_write(CFG_AW'(k), (phase == 1) ? '1 : random_binding());
    end
    cfg_write(REG_DWIN, {WORD_W'($urandom) << TIMER_W} | WORD_W'(dwin));
    cfg_write(REG_UNUSED, WORD_W'({$urandom, $urandom}));
    cfg_done();
    calm = (phase == 2);
  endtask

  task automatic run_random(int count);
    int               done;
    int               pick;
    logic [1:0]       act;
    logic [CODE_W-1:0] idx;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      act = ($urandom_range(9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
      if (pick < 38) begin
        idx = ($urandom_range(99) < 85) ? hot_keys[$urandom_range(7)]
                                        : CODE_W'($urandom_range(KEY_COUNT - 1));
        send_item(FUNC_KEY, idx, act, DT_W'($urandom));
        done++;
      end else if (pick < 50) begin
        idx = ($urandom_range(99) < 80) ? CODE_W'($urandom_range(BUTTON_COUNT - 1))
                                        : CODE_W'($urandom);
        send_item(FUNC_BTN, idx, act, DT_W'($urandom));
        done++;
      end else if (pick < 92) begin
        send_item(FUNC_FRAME, CODE_W'($urandom), 2'($urandom), random_step());
        done++;
      end else begin
        send_item(FUNC_NONE, CODE_W'($urandom), 2'($urandom), DT_W'($urandom));
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    func       <= FUNC_KEY;
    index      <= '0;
    action     <= ACT_RELEASE;
    elapsed_us <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(p);
      run_random(PHASE_ITEMS);
    end
    drain();
    if (sb.pending() != 0) begin
      $display("%0t: %0d fired_mask beats never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[input_binding_trigger_detector] OK");
    end else begin
      $display("[input_binding_trigger_detector] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[input_binding_trigger_detector] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ibtd_pkg.sv
src/ibtd_alu.sv
src/ibtd_keymap.sv
src/input_binding_trigger_detector.sv
tb/tb_input_binding_trigger_detector.sv
